// ----- rtl/core/slc_pkg.sv -----
package slc_pkg;

    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ID_W       = 32;
    localparam int COORD_W    = 20;
    localparam int FRAC_BITS  = 10;
    localparam int TGT_W      = 7;
    localparam int CI_W       = 6;
    localparam int ERR_W      = 2;

    localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(1000 << FRAC_BITS);

    // squared distance, its integer part, and the root of that
    localparam int SQ_W   = 2 * COORD_W + 1;
    localparam int RAD_W  = SQ_W - 2 * FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int DIST_W = ROOT_W;
    localparam logic [DIST_W-1:0] DIST_CAP = DIST_W'(1414);

    // dist unit latency from presented operands to result
    localparam int PIPE_LAT = ROOT_W + 3;
    localparam int DRAIN_W  = $clog2(PIPE_LAT + 1);

    localparam int KEY_W = ID_W + IDX_W;

    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_COORD  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TARGET = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL   = 2'd3;

    typedef struct packed {
        logic signed [ID_W-1:0]    id;
        logic        [COORD_W-1:0] x;
        logic        [COORD_W-1:0] y;
    } t_point;

    typedef logic [2*ROOT_W-1:0] t_rad;

    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        t_rad              rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_stage;

    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        logic [DIST_W-1:0] d;
    } t_pair_res;

endpackage

// ----- rtl/core/slc_ram.sv -----
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/core/slc_sqrt_cell.sv -----
module slc_sqrt_cell
    import slc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sq_stage i_stage,
    output t_sq_stage o_stage
);

    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    t_sq_stage          n_stage;
    logic               r_vld;
    logic [IDX_W-1:0]   r_a;
    logic [IDX_W-1:0]   r_b;
    t_rad               r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;

    // one root bit: bring down two radicand bits, try subtracting 4r+1
    always_comb begin
        rem_sh  = {i_stage.rem[REM_W-3:0], i_stage.rad[2*ROOT_W-1 -: 2]};
        trial   = {i_stage.root, 2'b01};
        n_stage = i_stage;
        n_stage.rad = i_stage.rad << 2;
        if (rem_sh >= trial) begin
            n_stage.rem  = rem_sh - trial;
            n_stage.root = {i_stage.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_stage.rem  = rem_sh;
            n_stage.root = {i_stage.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_stage.a;
        r_b    <= n_stage.b;
        r_rad  <= n_stage.rad;
        r_rem  <= n_stage.rem;
        r_root <= n_stage.root;
    end

    assign o_stage = '{vld: r_vld, a: r_a, b: r_b, rad: r_rad, rem: r_rem, root: r_root};

endmodule

// ----- rtl/core/slc_dist.sv -----
module slc_dist
    import slc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_point           i_pt_p,
    input  t_point           i_pt_q,
    input  logic [IDX_W-1:0] i_lbl_p,
    input  logic [IDX_W-1:0] i_lbl_q,
    output t_pair_res        o_res
);

    logic                 r_s1_vld;
    logic [IDX_W-1:0]     r_s1_a;
    logic [IDX_W-1:0]     r_s1_b;
    logic [COORD_W-1:0]   r_s1_dx;
    logic [COORD_W-1:0]   r_s1_dy;
    logic                 r_s2_vld;
    logic [IDX_W-1:0]     r_s2_a;
    logic [IDX_W-1:0]     r_s2_b;
    logic [2*COORD_W-1:0] r_s2_sqx;
    logic [2*COORD_W-1:0] r_s2_sqy;
    logic                 r_s3_vld;
    logic [IDX_W-1:0]     r_s3_a;
    logic [IDX_W-1:0]     r_s3_b;
    t_rad                 r_s3_rad;
    logic [SQ_W-1:0]      sq_sum;
    t_sq_stage            w_chain [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            // drop pairs already in one cluster
            r_s1_vld <= i_vld && (i_lbl_p != i_lbl_q);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    assign sq_sum = SQ_W'(r_s2_sqx) + SQ_W'(r_s2_sqy);

    always_ff @(posedge i_clk) begin
        r_s1_a   <= (i_lbl_p < i_lbl_q) ? i_lbl_p : i_lbl_q;
        r_s1_b   <= (i_lbl_p < i_lbl_q) ? i_lbl_q : i_lbl_p;
        r_s1_dx  <= (i_pt_p.x > i_pt_q.x) ? i_pt_p.x - i_pt_q.x : i_pt_q.x - i_pt_p.x;
        r_s1_dy  <= (i_pt_p.y > i_pt_q.y) ? i_pt_p.y - i_pt_q.y : i_pt_q.y - i_pt_p.y;
        r_s2_a   <= r_s1_a;
        r_s2_b   <= r_s1_b;
        r_s2_sqx <= r_s1_dx * r_s1_dx;
        r_s2_sqy <= r_s1_dy * r_s1_dy;
        r_s3_a   <= r_s2_a;
        r_s3_b   <= r_s2_b;
        r_s3_rad <= t_rad'(sq_sum >> (2 * FRAC_BITS));
    end

    assign w_chain[0] = '{vld: r_s3_vld, a: r_s3_a, b: r_s3_b, rad: r_s3_rad,
                          rem: '0, root: '0};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        slc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    always_comb begin
        o_res.vld = w_chain[ROOT_W].vld;
        o_res.a   = w_chain[ROOT_W].a;
        o_res.b   = w_chain[ROOT_W].b;
        o_res.d   = (w_chain[ROOT_W].root > DIST_CAP) ? DIST_CAP : w_chain[ROOT_W].root;
    end

endmodule

// ----- rtl/core/single_linkage_clustering_top.sv -----
// Loading: one point per cycle, no stall while loading.
// After the last point: a check state, then per merge round every pair of points goes
// through the distance pipeline, followed by a pipeline drain and a relabel pass.
// Output: each member costs one scan over all points, plus one empty scan per point index.
// Throughput is one data set at a time; the next load starts after the final beat is queued.
// Reset (synchronous, active low) clears control, counts and errors; point memories are not cleared.
module single_linkage_clustering_top
    import slc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [ID_W-1:0]    i_object_id,
    input  logic        [COORD_W-1:0] i_x_coord,
    input  logic        [COORD_W-1:0] i_y_coord,
    input  logic                      i_last_point,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic        [CI_W-1:0]    o_cluster_index,
    output logic signed [ID_W-1:0]    o_member_id,
    output logic        [COORD_W-1:0] o_member_x,
    output logic        [COORD_W-1:0] o_member_y,
    output logic                      o_last_of_cluster,
    output logic                      o_last_of_run,
    output logic        [ERR_W-1:0]   o_error_code,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic        [TGT_W-1:0]   i_cfg_data
);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_ERR   = 11'b000_0000_0100,
        S_PAIRS = 11'b000_0000_1000,
        S_DRAIN = 11'b000_0001_0000,
        S_MERGE = 11'b000_0010_0000,
        S_MWAIT = 11'b000_0100_0000,
        S_SCAN  = 11'b000_1000_0000,
        S_SWAIT = 11'b001_0000_0000,
        S_PUSH  = 11'b010_0000_0000,
        S_FINAL = 11'b100_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ERR_W-1:0]   r_err, n_err;
    logic [TGT_W-1:0]   r_tgt_cfg, n_tgt_cfg;
    logic [TGT_W-1:0]   r_tgt, n_tgt;
    logic [CNT_W-1:0]   r_ccnt, n_ccnt;
    logic [CNT_W-1:0]   r_p, n_p;
    logic [CNT_W-1:0]   r_q, n_q;
    logic [CNT_W-1:0]   r_a, n_a;
    logic [DRAIN_W-1:0] r_drain, n_drain;
    logic               r_found, n_found;
    logic [DIST_W-1:0]  r_bd, n_bd;
    logic [IDX_W-1:0]   r_ba, n_ba;
    logic [IDX_W-1:0]   r_bb, n_bb;
    logic               r_pair_iss, r_merge_iss, r_scan_iss;
    logic [IDX_W-1:0]   r_rd_p;
    logic               r_have_last, n_have_last;
    logic [KEY_W-1:0]   r_last_key, n_last_key;
    logic               r_sel_found, n_sel_found;
    logic [KEY_W-1:0]   r_sel_key, n_sel_key;
    t_point             r_sel_pt, n_sel_pt;
    logic               r_any, n_any;
    logic [CI_W-1:0]    r_ci, n_ci;
    logic               r_pend_vld, n_pend_vld;
    logic [CI_W-1:0]    r_pend_ci, n_pend_ci;
    t_point             r_pend_pt, n_pend_pt;
    logic               r_out_vld, n_out_vld;
    logic [CI_W-1:0]    r_out_ci, n_out_ci;
    t_point             r_out_pt, n_out_pt;
    logic               r_out_loc, n_out_loc;
    logic               r_out_lor, n_out_lor;
    logic [ERR_W-1:0]   r_out_err, n_out_err;

    logic               accept, load_ok, out_free;
    logic [TGT_W-1:0]   tgt_eff;
    logic [CNT_W-1:0]   ccnt_dec;
    logic [KEY_W-1:0]   key;
    logic               cand;
    t_point             in_pt;
    t_point             pt_rd_a, pt_rd_b;
    logic [IDX_W-1:0]   lbl_rd_a, lbl_rd_b;
    logic               pt_we, lbl_we;
    logic [IDX_W-1:0]   lbl_waddr, lbl_wdata;
    t_pair_res          pres;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;

    assign in_pt.id = i_object_id;
    assign in_pt.x  = i_x_coord;
    assign in_pt.y  = i_y_coord;

    assign load_ok = (r_count < CNT_W'(MAX_POINTS))
                  && (i_x_coord <= COORD_LIMIT) && (i_y_coord <= COORD_LIMIT);

    assign pt_we     = accept && load_ok;
    assign lbl_we    = pt_we || (r_merge_iss && (lbl_rd_a == r_bb));
    assign lbl_waddr = (r_state == S_LOAD) ? r_count[IDX_W-1:0] : r_rd_p;
    assign lbl_wdata = (r_state == S_LOAD) ? r_count[IDX_W-1:0] : r_ba;

    slc_ram #(.WIDTH($bits(t_point)), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk     (i_clk),
        .i_we      (pt_we),
        .i_waddr   (r_count[IDX_W-1:0]),
        .i_wdata   (in_pt),
        .i_raddr_a (r_p[IDX_W-1:0]),
        .i_raddr_b (r_q[IDX_W-1:0]),
        .o_rdata_a (pt_rd_a),
        .o_rdata_b (pt_rd_b)
    );

    slc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_lbl_ram (
        .i_clk     (i_clk),
        .i_we      (lbl_we),
        .i_waddr   (lbl_waddr),
        .i_wdata   (lbl_wdata),
        .i_raddr_a (r_p[IDX_W-1:0]),
        .i_raddr_b (r_q[IDX_W-1:0]),
        .o_rdata_a (lbl_rd_a),
        .o_rdata_b (lbl_rd_b)
    );

    slc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_pair_iss),
        .i_pt_p  (pt_rd_a),
        .i_pt_q  (pt_rd_b),
        .i_lbl_p (lbl_rd_a),
        .i_lbl_q (lbl_rd_b),
        .o_res   (pres)
    );

    // member order key: signed id made unsigned, then load index
    assign key  = {~pt_rd_a.id[ID_W-1], pt_rd_a.id[ID_W-2:0], r_rd_p};
    assign cand = r_scan_iss && (lbl_rd_a == r_a[IDX_W-1:0])
               && (!r_have_last || key > r_last_key)
               && (!r_sel_found || key < r_sel_key);

    assign tgt_eff  = (r_tgt_cfg == '0) ? TGT_W'(1) : r_tgt_cfg;
    assign ccnt_dec = r_ccnt - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_tgt_cfg   = i_cfg_valid ? i_cfg_data : r_tgt_cfg;
        n_tgt       = r_tgt;
        n_ccnt      = r_ccnt;
        n_p         = r_p;
        n_q         = r_q;
        n_a         = r_a;
        n_drain     = r_drain;
        n_found     = r_found;
        n_bd        = r_bd;
        n_ba        = r_ba;
        n_bb        = r_bb;
        n_have_last = r_have_last;
        n_last_key  = r_last_key;
        n_sel_found = r_sel_found;
        n_sel_key   = r_sel_key;
        n_sel_pt    = r_sel_pt;
        n_any       = r_any;
        n_ci        = r_ci;
        n_pend_vld  = r_pend_vld;
        n_pend_ci   = r_pend_ci;
        n_pend_pt   = r_pend_pt;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out_ci    = r_out_ci;
        n_out_pt    = r_out_pt;
        n_out_loc   = r_out_loc;
        n_out_lor   = r_out_lor;
        n_out_err   = r_out_err;

        // keep the closest pair, lowest cluster pair on a tie
        if (pres.vld && (!r_found || pres.d < r_bd
                || (pres.d == r_bd && {pres.a, pres.b} < {r_ba, r_bb}))) begin
            n_found = 1'b1;
            n_bd    = pres.d;
            n_ba    = pres.a;
            n_bb    = pres.b;
        end

        if (cand) begin
            n_sel_found = 1'b1;
            n_sel_key   = key;
            n_sel_pt    = pt_rd_a;
        end

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_count >= CNT_W'(MAX_POINTS)) begin
                        if (r_err == ERR_NONE) n_err = ERR_FULL;
                    end else if (!load_ok) begin
                        if (r_err == ERR_NONE) n_err = ERR_COORD;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_last_point) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_tgt      = tgt_eff;
                n_ccnt     = r_count;
                n_pend_vld = 1'b0;
                if (r_err != ERR_NONE) begin
                    n_state = S_ERR;
                end else if (tgt_eff > TGT_W'(r_count)) begin
                    n_err   = ERR_TARGET;
                    n_state = S_ERR;
                end else if (TGT_W'(r_count) > tgt_eff) begin
                    n_p     = '0;
                    n_q     = CNT_W'(1);
                    n_found = 1'b0;
                    n_state = S_PAIRS;
                end else begin
                    n_a         = '0;
                    n_p         = '0;
                    n_have_last = 1'b0;
                    n_sel_found = 1'b0;
                    n_any       = 1'b0;
                    n_ci        = '0;
                    n_state     = S_SCAN;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_ci  = '0;
                    n_out_pt  = '0;
                    n_out_loc = 1'b0;
                    n_out_lor = 1'b1;
                    n_out_err = r_err;
                    n_count   = '0;
                    n_err     = ERR_NONE;
                    n_state   = S_LOAD;
                end
            end
            S_PAIRS: begin
                if (CNT_W'(r_q + 1'b1) == r_count) begin
                    if (CNT_W'(r_p + 2'd2) == r_count) begin
                        n_drain = DRAIN_W'(PIPE_LAT);
                        n_state = S_DRAIN;
                    end else begin
                        n_p = r_p + 1'b1;
                        n_q = r_p + 2'd2;
                    end
                end else begin
                    n_q = r_q + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_drain == '0) begin
                    n_p     = '0;
                    n_state = S_MERGE;
                end else begin
                    n_drain = r_drain - 1'b1;
                end
            end
            S_MERGE: begin
                if (CNT_W'(r_p + 1'b1) == r_count) n_state = S_MWAIT;
                else n_p = r_p + 1'b1;
            end
            S_MWAIT: begin
                n_ccnt = ccnt_dec;
                if (TGT_W'(ccnt_dec) > r_tgt) begin
                    n_p     = '0;
                    n_q     = CNT_W'(1);
                    n_found = 1'b0;
                    n_state = S_PAIRS;
                end else begin
                    n_a         = '0;
                    n_p         = '0;
                    n_have_last = 1'b0;
                    n_sel_found = 1'b0;
                    n_any       = 1'b0;
                    n_ci        = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (CNT_W'(r_p + 1'b1) == r_count) n_state = S_SWAIT;
                else n_p = r_p + 1'b1;
            end
            S_SWAIT: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (r_sel_found) begin
                    if (!r_pend_vld || out_free) begin
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_out_ci  = r_pend_ci;
                            n_out_pt  = r_pend_pt;
                            n_out_loc = (r_pend_ci != r_ci);
                            n_out_lor = 1'b0;
                            n_out_err = ERR_NONE;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_ci   = r_ci;
                        n_pend_pt   = r_sel_pt;
                        n_last_key  = r_sel_key;
                        n_have_last = 1'b1;
                        n_any       = 1'b1;
                        n_sel_found = 1'b0;
                        n_p         = '0;
                        n_state     = S_SCAN;
                    end
                end else begin
                    // no more members under this label: advance to the next one
                    if (r_any) n_ci = r_ci + 1'b1;
                    n_any       = 1'b0;
                    n_have_last = 1'b0;
                    n_p         = '0;
                    n_a         = r_a + 1'b1;
                    if (CNT_W'(r_a + 1'b1) == r_count) n_state = S_FINAL;
                    else n_state = S_SCAN;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_ci   = r_pend_ci;
                    n_out_pt   = r_pend_pt;
                    n_out_loc  = 1'b1;
                    n_out_lor  = 1'b1;
                    n_out_err  = ERR_NONE;
                    n_pend_vld = 1'b0;
                    n_count    = '0;
                    n_err      = ERR_NONE;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_err       <= ERR_NONE;
            r_tgt_cfg   <= TGT_W'(1);
            r_tgt       <= TGT_W'(1);
            r_ccnt      <= '0;
            r_p         <= '0;
            r_q         <= '0;
            r_a         <= '0;
            r_drain     <= '0;
            r_found     <= 1'b0;
            r_pair_iss  <= 1'b0;
            r_merge_iss <= 1'b0;
            r_scan_iss  <= 1'b0;
            r_have_last <= 1'b0;
            r_sel_found <= 1'b0;
            r_any       <= 1'b0;
            r_ci        <= '0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_tgt_cfg   <= n_tgt_cfg;
            r_tgt       <= n_tgt;
            r_ccnt      <= n_ccnt;
            r_p         <= n_p;
            r_q         <= n_q;
            r_a         <= n_a;
            r_drain     <= n_drain;
            r_found     <= n_found;
            r_pair_iss  <= (r_state == S_PAIRS);
            r_merge_iss <= (r_state == S_MERGE);
            r_scan_iss  <= (r_state == S_SCAN);
            r_have_last <= n_have_last;
            r_sel_found <= n_sel_found;
            r_any       <= n_any;
            r_ci        <= n_ci;
            r_pend_vld  <= n_pend_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bd       <= n_bd;
        r_ba       <= n_ba;
        r_bb       <= n_bb;
        r_rd_p     <= r_p[IDX_W-1:0];
        r_last_key <= n_last_key;
        r_sel_key  <= n_sel_key;
        r_sel_pt   <= n_sel_pt;
        r_pend_ci  <= n_pend_ci;
        r_pend_pt  <= n_pend_pt;
        r_out_ci   <= n_out_ci;
        r_out_pt   <= n_out_pt;
        r_out_loc  <= n_out_loc;
        r_out_lor  <= n_out_lor;
        r_out_err  <= n_out_err;
    end

    assign o_out_valid       = r_out_vld;
    assign o_cluster_index   = r_out_ci;
    assign o_member_id       = r_out_pt.id;
    assign o_member_x        = r_out_pt.x;
    assign o_member_y        = r_out_pt.y;
    assign o_last_of_cluster = r_out_loc;
    assign o_last_of_run     = r_out_lor;
    assign o_error_code      = r_out_err;

`ifndef SYNTHESIS
    a_err_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != ERR_NONE) |-> o_last_of_run)
        else $error("error beat without end of run");

    a_run_ends_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run && o_error_code == ERR_NONE) |-> o_last_of_cluster)
        else $error("end of run inside a cluster");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_merge_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> r_found)
        else $error("merge without a chosen pair");
`endif

endmodule
